[src/rover_first_fit_block_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the rover first-fit block allocator.
// RFFBA_ASSERT checks a property on clock, disabled while reset is high.
// RFFBA_ASSERT_NORST checks a property on clock at every edge.
// ----------------------------------------------------------------------------
`ifndef ROVER_FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define ROVER_FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define RFFBA_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define RFFBA_ASSERT_NORST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) else $error("assertion failed");
`else
`define RFFBA_ASSERT(lbl, prop)
`define RFFBA_ASSERT_NORST(lbl, prop)
`endif
`endif

[src/rffba_pkg.sv]
// ----------------------------------------------------------------------------
// rffba_pkg
// Types, codes and constants shared by the allocator controller and datapath.
// ----------------------------------------------------------------------------
package rffba_pkg;

   localparam int MEM_WORDS_DEF = 16384;
   localparam int HEAP_BASE_DEF = 20;

   localparam int WORD_W     = 32;
   localparam int HALF_W     = 16;
   localparam int PTR_W      = 17;
   localparam int SIZE_W     = 14;
   localparam int CHUNK_W    = 14;
   localparam int TOP_W      = 15;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam logic [HALF_W-1:0]  EMPTY_MARK = 16'hFFFF;
   localparam logic [HALF_W-1:0]  INIT_BLOCK = 16'd1000;
   localparam logic [CHUNK_W-1:0] GROW_RESET = 14'd1000;
   localparam logic [TOP_W-1:0]   TOP_RESET  = 15'd12288;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC    = 2'd0,
      OP_FREE     = 2'd1,
      OP_COALESCE = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_GROW_CHUNK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_LIMIT  = 2'd1;

   typedef enum logic [5:0] {
      CMD_CLR, CMD_IDLE, CMD_FIN,
      CMD_FRD, CMD_FW0, CMD_FW1, CMD_FW2, CMD_FW3,
      CMD_ASTART, CMD_ARDP, CMD_AGOTP, CMD_ARDQ, CMD_AGOTQ,
      CMD_ARDQ1, CMD_AGOTQ1, CMD_AW1, CMD_AW2, CMD_ARDSZ, CMD_AGOTSZ,
      CMD_CARVE1, CMD_CARVE2, CMD_ARDP1, CMD_AGOTP1,
      CMD_EX1, CMD_EX2, CMD_EX3,
      CMD_GRD, CMD_GGOT, CMD_G2, CMD_G3, CMD_G4, CMD_G5
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic out_free;
      logic mark_free;
      logic carve_fit;
      logic exact_fit;
      logic step_over;
      logic p_wrap;
      logic merge_only;
      logic grow_ok;
   } stat_type;

endpackage

[src/rffba_ctrl.sv]
// ----------------------------------------------------------------------------
// rffba_ctrl
// Sequencer for clear, free, allocate, coalesce and heap growth.
// ----------------------------------------------------------------------------
`include "rover_first_fit_block_allocator_macros.svh"
module rffba_ctrl
   import rffba_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_op,
   output logic            req_ready,
   input  stat_type        stat,
   output cmd_type         cmd
);

   localparam int ST_W = 32;

   typedef enum logic [ST_W-1:0] {
      S_CLR    = ST_W'(1) << 0,  S_IDLE   = ST_W'(1) << 1,  S_FIN    = ST_W'(1) << 2,
      S_FRD    = ST_W'(1) << 3,  S_FW0    = ST_W'(1) << 4,  S_FW1    = ST_W'(1) << 5,
      S_FW2    = ST_W'(1) << 6,  S_FW3    = ST_W'(1) << 7,  S_ASTART = ST_W'(1) << 8,
      S_ARDP   = ST_W'(1) << 9,  S_AGOTP  = ST_W'(1) << 10, S_ARDQ   = ST_W'(1) << 11,
      S_AGOTQ  = ST_W'(1) << 12, S_ARDQ1  = ST_W'(1) << 13, S_AGOTQ1 = ST_W'(1) << 14,
      S_AW1    = ST_W'(1) << 15, S_AW2    = ST_W'(1) << 16, S_ARDSZ  = ST_W'(1) << 17,
      S_AGOTSZ = ST_W'(1) << 18, S_CARVE1 = ST_W'(1) << 19, S_CARVE2 = ST_W'(1) << 20,
      S_ARDP1  = ST_W'(1) << 21, S_AGOTP1 = ST_W'(1) << 22, S_EX1    = ST_W'(1) << 23,
      S_EX2    = ST_W'(1) << 24, S_EX3    = ST_W'(1) << 25, S_GRD    = ST_W'(1) << 26,
      S_GGOT   = ST_W'(1) << 27, S_G2     = ST_W'(1) << 28, S_G3     = ST_W'(1) << 29,
      S_G4     = ST_W'(1) << 30, S_G5     = ST_W'(1) << 31
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_IDLE;
      unique case (state_ff)
         S_CLR: begin
            cmd = CMD_CLR;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd = CMD_IDLE;
            if (req_valid) begin
               unique case (op_type'(req_op))
                  OP_ALLOC, OP_COALESCE: state_in = S_ASTART;
                  OP_FREE:               state_in = S_FRD;
                  OP_NONE:               state_in = S_FIN;
               endcase
            end
         end
         S_FIN: begin
            cmd = CMD_FIN;
            if (stat.out_free) state_in = S_IDLE;
         end
         S_FRD:    begin cmd = CMD_FRD;    state_in = S_FW0;    end
         S_FW0:    begin cmd = CMD_FW0;    state_in = S_FW1;    end
         S_FW1:    begin cmd = CMD_FW1;    state_in = S_FW2;    end
         S_FW2:    begin cmd = CMD_FW2;    state_in = S_FW3;    end
         S_FW3:    begin cmd = CMD_FW3;    state_in = S_FIN;    end
         S_ASTART: begin cmd = CMD_ASTART; state_in = S_ARDP;   end
         S_ARDP:   begin cmd = CMD_ARDP;   state_in = S_AGOTP;  end
         S_AGOTP:  begin cmd = CMD_AGOTP;  state_in = S_ARDQ;   end
         S_ARDQ:   begin cmd = CMD_ARDQ;   state_in = S_AGOTQ;  end
         S_AGOTQ: begin
            cmd = CMD_AGOTQ;
            priority if (stat.mark_free) state_in = S_ARDQ1;
            else if (stat.carve_fit)     state_in = S_CARVE1;
            else                         state_in = S_ARDP1;
         end
         S_ARDQ1:  begin cmd = CMD_ARDQ1;  state_in = S_AGOTQ1; end
         S_AGOTQ1: begin
            cmd      = CMD_AGOTQ1;
            state_in = stat.step_over ? S_FIN : S_AW1;
         end
         S_AW1:    begin cmd = CMD_AW1;    state_in = S_AW2;    end
         S_AW2:    begin cmd = CMD_AW2;    state_in = S_ARDSZ;  end
         S_ARDSZ:  begin cmd = CMD_ARDSZ;  state_in = S_AGOTSZ; end
         S_AGOTSZ: begin cmd = CMD_AGOTSZ; state_in = S_ARDQ;   end
         S_CARVE1: begin cmd = CMD_CARVE1; state_in = S_CARVE2; end
         S_CARVE2: begin cmd = CMD_CARVE2; state_in = S_FIN;    end
         S_ARDP1:  begin cmd = CMD_ARDP1;  state_in = S_AGOTP1; end
         S_AGOTP1: begin
            cmd = CMD_AGOTP1;
            priority if (stat.exact_fit) state_in = S_EX1;
            else if (stat.step_over)     state_in = S_FIN;
            else if (!stat.p_wrap)       state_in = S_ARDP;
            else if (stat.merge_only)    state_in = S_FIN;
            else if (stat.grow_ok)       state_in = S_GRD;
            else                         state_in = S_FIN;
         end
         S_EX1:    begin cmd = CMD_EX1;    state_in = S_EX2;    end
         S_EX2:    begin cmd = CMD_EX2;    state_in = S_EX3;    end
         S_EX3:    begin cmd = CMD_EX3;    state_in = S_FIN;    end
         S_GRD:    begin cmd = CMD_GRD;    state_in = S_GGOT;   end
         S_GGOT:   begin cmd = CMD_GGOT;   state_in = S_G2;     end
         S_G2:     begin cmd = CMD_G2;     state_in = S_G3;     end
         S_G3:     begin cmd = CMD_G3;     state_in = S_G4;     end
         S_G4:     begin cmd = CMD_G4;     state_in = S_G5;     end
         S_G5:     begin cmd = CMD_G5;     state_in = S_ASTART; end
         default: begin
            cmd      = CMD_CLR;
            state_in = S_CLR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   `RFFBA_ASSERT(a_accept_leaves_idle, req_valid && req_ready |=> state_ff != S_IDLE)
   `RFFBA_ASSERT(a_fin_holds, state_ff == S_FIN && !stat.out_free |=> state_ff == S_FIN)
   `RFFBA_ASSERT(a_clr_holds, state_ff == S_CLR && !stat.clr_done |=> state_ff == S_CLR)

endmodule

[src/rffba_dpath.sv]
// ----------------------------------------------------------------------------
// rffba_dpath
// Heap memory, pointer registers, configuration and result register.
// ----------------------------------------------------------------------------
`include "rover_first_fit_block_allocator_macros.svh"
module rffba_dpath
   import rffba_pkg::*;
#(
   parameter int MEM_WORDS = MEM_WORDS_DEF,
   parameter int HEAP_BASE = HEAP_BASE_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic                  req_valid,
   input  logic [OP_W-1:0]       req_op,
   input  logic [SIZE_W-1:0]     req_block_size,
   input  logic [SIZE_W-1:0]     req_block_addr,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [HALF_W-1:0]     rsp_result_addr,
   output logic                  rsp_status
);

   localparam int AW         = $clog2(MEM_WORDS);
   localparam int WALK_LIMIT = 2 * MEM_WORDS + 4;
   localparam int STEP_W     = $clog2(WALK_LIMIT + 2);
   localparam logic [PTR_W-1:0]  MEM_LIM  = PTR_W'(MEM_WORDS);
   localparam logic [PTR_W-1:0]  MEM_MAX  = PTR_W'(MEM_WORDS - 1);
   localparam logic [AW-1:0]     CLR_LAST = AW'(MEM_WORDS - 1);
   localparam logic [HALF_W-1:0] HB       = HALF_W'(HEAP_BASE);
   localparam logic [HALF_W-1:0] HE_RESET = HALF_W'(HEAP_BASE + int'(INIT_BLOCK));

   logic [WORD_W-1:0] mem [MEM_WORDS];

   logic [WORD_W-1:0]  rd_ff;
   logic [PTR_W-1:0]   rd_addr;
   logic               wr_en, wr_hi, wr_lo;
   logic [PTR_W-1:0]   wr_addr;
   logic [WORD_W-1:0]  wr_data;

   logic [HALF_W-1:0]  p_ff, p_in, t_ff, t_in, l_ff, l_in;
   logic [PTR_W-1:0]   q_ff, q_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic [HALF_W-1:0]  rover_ff, rover_in, he_ff, he_in;
   logic [HALF_W-1:0]  res_ff, res_in;
   logic               st_ff, st_in, mo_ff, mo_in;
   logic [SIZE_W-1:0]  s_ff, s_in, a_ff, a_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [CHUNK_W-1:0] grow_ff;
   logic [TOP_W-1:0]   top_ff;
   logic               rsp_valid_ff;
   logic [HALF_W-1:0]  rsp_addr_ff;
   logic               rsp_status_ff;

   logic [HALF_W-1:0]  rd_hi, rd_lo, a16;
   logic [PTR_W-1:0]   p17, s17, ps, r, he17, he2, top17, sumc, halfsum, tsel;
   logic [HALF_W-1:0]  tnew, carve_sz, merge_sz;
   logic [STEP_W:0]    steps_inc;
   logic [CHUNK_W-1:0] chunk;
   logic [WORD_W-1:0]  init_word;
   logic               over, grow_ok, exact, load_rsp;

   assign rd_hi    = rd_ff[WORD_W-1:HALF_W];
   assign rd_lo    = rd_ff[HALF_W-1:0];
   assign a16      = HALF_W'(a_ff);
   assign p17      = PTR_W'(p_ff);
   assign s17      = PTR_W'(s_ff);
   assign ps       = p17 + s17;
   assign r        = q_ff - s17;
   assign carve_sz = HALF_W'(r - p17);
   assign merge_sz = HALF_W'(q_ff - p17);

   assign steps_inc = (STEP_W+1)'(steps_ff) + (STEP_W+1)'(1);
   assign over      = steps_inc > (STEP_W+1)'(WALK_LIMIT);

   // growth target: chunk above end, else halfway to the top limit, capped
   assign he17    = PTR_W'(he_ff);
   assign he2     = he17 + PTR_W'(2);
   assign top17   = PTR_W'(top_ff);
   assign grow_ok = (he2 < top17) && (he2 <= MEM_MAX);
   assign chunk   = (grow_ff == '0) ? CHUNK_W'(1) : grow_ff;
   assign sumc    = he17 + PTR_W'(chunk);
   assign halfsum = (he17 + top17 + PTR_W'(2)) >> 1;
   assign tsel    = (sumc < top17) ? sumc : halfsum;
   assign tnew    = HALF_W'((tsel > MEM_MAX) ? MEM_MAX : tsel);

   assign exact = !mo_ff && (q_ff == ps) && (rd_lo != rover_ff || rd_hi != rover_ff);

   assign load_rsp = (cmd == CMD_FIN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      init_word = '0;
      if (clr_ff == AW'(HEAP_BASE)) init_word = {INIT_BLOCK, EMPTY_MARK};
      else if (clr_ff == AW'(HEAP_BASE + 1)) init_word = {HB, HB};
   end

   assign stat.clr_done   = (clr_ff == CLR_LAST);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign stat.mark_free  = (rd_lo == EMPTY_MARK);
   assign stat.carve_fit  = !mo_ff && (q_ff > ps + PTR_W'(1));
   assign stat.exact_fit  = exact;
   assign stat.step_over  = over;
   assign stat.p_wrap     = (rd_lo == rover_ff);
   assign stat.merge_only = mo_ff;
   assign stat.grow_ok    = grow_ok;

   always_comb begin
      p_in     = p_ff;
      q_in     = q_ff;
      t_in     = t_ff;
      l_in     = l_ff;
      steps_in = steps_ff;
      rover_in = rover_ff;
      he_in    = he_ff;
      res_in   = res_ff;
      st_in    = st_ff;
      mo_in    = mo_ff;
      s_in     = s_ff;
      a_in     = a_ff;
      clr_in   = clr_ff;
      rd_addr  = q_ff;
      wr_en    = 1'b0;
      wr_hi    = 1'b0;
      wr_lo    = 1'b0;
      wr_addr  = q_ff;
      wr_data  = '0;
      unique case (cmd)
         CMD_CLR: begin
            wr_en   = 1'b1; wr_hi = 1'b1; wr_lo = 1'b1;
            wr_addr = PTR_W'(clr_ff);
            wr_data = init_word;
            clr_in  = clr_ff + AW'(1);
         end
         CMD_IDLE: begin
            if (req_valid) begin
               s_in   = (req_block_size == '0) ? SIZE_W'(1) : req_block_size;
               a_in   = req_block_addr;
               mo_in  = (req_op == OP_COALESCE);
               res_in = '0;
               st_in  = 1'b0;
            end
         end
         CMD_FIN: ;
         CMD_FRD:    rd_addr = PTR_W'(rover_ff) + PTR_W'(1);
         CMD_FW0: begin
            l_in    = rd_hi;
            wr_en   = 1'b1; wr_hi = 1'b1; wr_lo = 1'b1;
            wr_addr = PTR_W'(a_ff);
            wr_data = {HALF_W'(s_ff), EMPTY_MARK};
         end
         CMD_FW1: begin
            wr_en   = 1'b1; wr_hi = 1'b1; wr_lo = 1'b1;
            wr_addr = PTR_W'(a_ff) + PTR_W'(1);
            wr_data = {l_ff, rover_ff};
         end
         CMD_FW2: begin
            wr_en   = 1'b1; wr_hi = 1'b1;
            wr_addr = PTR_W'(rover_ff) + PTR_W'(1);
            wr_data = {a16, HALF_W'(0)};
         end
         CMD_FW3: begin
            wr_en   = 1'b1; wr_lo = 1'b1;
            wr_addr = PTR_W'(l_ff) + PTR_W'(1);
            wr_data = {HALF_W'(0), a16};
         end
         CMD_ASTART: begin
            p_in     = rover_ff;
            steps_in = '0;
         end
         CMD_ARDP:   rd_addr = p17;
         CMD_AGOTP:  q_in = p17 + PTR_W'(rd_hi);
         CMD_ARDQ:   rd_addr = q_ff;
         CMD_AGOTQ:  ;
         CMD_ARDQ1:  rd_addr = q_ff + PTR_W'(1);
         CMD_AGOTQ1: begin
            t_in = rd_lo;
            l_in = rd_hi;
            if (over) begin
               st_in  = 1'b1;
               res_in = '0;
            end else begin
               steps_in = STEP_W'(steps_inc);
               if (q_ff == PTR_W'(rover_ff)) rover_in = rd_lo;
            end
         end
         CMD_AW1: begin
            wr_en   = 1'b1; wr_hi = 1'b1;
            wr_addr = PTR_W'(t_ff) + PTR_W'(1);
            wr_data = {l_ff, HALF_W'(0)};
         end
         CMD_AW2: begin
            wr_en   = 1'b1; wr_lo = 1'b1;
            wr_addr = PTR_W'(l_ff) + PTR_W'(1);
            wr_data = {HALF_W'(0), t_ff};
         end
         CMD_ARDSZ:  rd_addr = q_ff;
         CMD_AGOTSZ: q_in = q_ff + PTR_W'(rd_hi);
         CMD_CARVE1: begin
            wr_en    = 1'b1; wr_hi = 1'b1;
            wr_addr  = p17;
            wr_data  = {carve_sz, HALF_W'(0)};
            rover_in = p_ff;
            res_in   = HALF_W'(r);
         end
         CMD_CARVE2: begin
            wr_en   = 1'b1; wr_lo = 1'b1;
            wr_addr = r;
         end
         CMD_ARDP1:  rd_addr = p17 + PTR_W'(1);
         CMD_AGOTP1: begin
            t_in = rd_lo;
            l_in = rd_hi;
            if (!exact) begin
               wr_en   = 1'b1; wr_hi = 1'b1;
               wr_addr = p17;
               wr_data = {merge_sz, HALF_W'(0)};
               p_in    = rd_lo;
               if (over) begin
                  st_in  = 1'b1;
                  res_in = '0;
               end else begin
                  steps_in = STEP_W'(steps_inc);
                  if (rd_lo == rover_ff) begin
                     if (mo_ff) begin
                        res_in = EMPTY_MARK;
                     end else if (!grow_ok) begin
                        st_in  = 1'b1;
                        res_in = '0;
                     end
                  end
               end
            end
         end
         CMD_EX1: begin
            rover_in = t_ff;
            wr_en    = 1'b1; wr_hi = 1'b1;
            wr_addr  = PTR_W'(t_ff) + PTR_W'(1);
            wr_data  = {l_ff, HALF_W'(0)};
            res_in   = p_ff;
         end
         CMD_EX2: begin
            wr_en   = 1'b1; wr_lo = 1'b1;
            wr_addr = PTR_W'(l_ff) + PTR_W'(1);
            wr_data = {HALF_W'(0), t_ff};
         end
         CMD_EX3: begin
            wr_en   = 1'b1; wr_lo = 1'b1;
            wr_addr = p17;
         end
         CMD_GRD: begin
            rd_addr = PTR_W'(rover_ff) + PTR_W'(1);
            t_in    = tnew;
         end
         CMD_GGOT: begin
            l_in    = rd_hi;
            wr_en   = 1'b1; wr_lo = 1'b1;
            wr_addr = PTR_W'(rd_hi) + PTR_W'(1);
            wr_data = {HALF_W'(0), he_ff};
         end
         CMD_G2: begin
            wr_en   = 1'b1; wr_hi = 1'b1;
            wr_addr = PTR_W'(rover_ff) + PTR_W'(1);
            wr_data = {he_ff, HALF_W'(0)};
         end
         CMD_G3: begin
            wr_en   = 1'b1; wr_hi = 1'b1; wr_lo = 1'b1;
            wr_addr = he17 + PTR_W'(1);
            wr_data = {l_ff, rover_ff};
         end
         CMD_G4: begin
            wr_en   = 1'b1; wr_hi = 1'b1; wr_lo = 1'b1;
            wr_addr = he17;
            wr_data = {t_ff - he_ff, EMPTY_MARK};
         end
         CMD_G5: begin
            wr_en    = 1'b1; wr_hi = 1'b1; wr_lo = 1'b1;
            wr_addr  = PTR_W'(t_ff);
            he_in    = t_ff;
            rover_in = he_ff;
         end
         default: ;
      endcase
   end

   // heap memory: one half-maskable write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en && wr_addr < MEM_LIM) begin
         if (wr_hi) mem[wr_addr[AW-1:0]][WORD_W-1:HALF_W] <= wr_data[WORD_W-1:HALF_W];
         if (wr_lo) mem[wr_addr[AW-1:0]][HALF_W-1:0] <= wr_data[HALF_W-1:0];
      end
      if (rd_addr < MEM_LIM) begin
         rd_ff <= mem[rd_addr[AW-1:0]];
      end else begin
         rd_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      q_ff     <= q_in;
      t_ff     <= t_in;
      l_ff     <= l_in;
      steps_ff <= steps_in;
      res_ff   <= res_in;
      st_ff    <= st_in;
      mo_ff    <= mo_in;
      s_ff     <= s_in;
      a_ff     <= a_in;
      if (load_rsp) begin
         rsp_addr_ff   <= res_ff;
         rsp_status_ff <= st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rover_ff     <= HB;
         he_ff        <= HE_RESET;
         grow_ff      <= GROW_RESET;
         top_ff       <= TOP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff   <= clr_in;
         rover_ff <= rover_in;
         he_ff    <= he_in;
         if (csr_valid) begin
            if (csr_index == CSR_GROW_CHUNK) grow_ff <= csr_wdata[CHUNK_W-1:0];
            else if (csr_index == CSR_TOP_LIMIT) top_ff <= csr_wdata[TOP_W-1:0];
         end
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_addr = rsp_addr_ff;
   assign rsp_status      = rsp_status_ff;

   `RFFBA_ASSERT(a_no_rsp_in_clear, cmd == CMD_CLR |-> !rsp_valid_ff)
   `RFFBA_ASSERT(a_grow_moves_rover, cmd == CMD_G5 |=> rover_ff == $past(he_ff))
   `RFFBA_ASSERT(a_carve_only_alloc, cmd == CMD_CARVE1 || cmd == CMD_EX1 |-> !mo_ff)

endmodule

[src/rover_first_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// rover_first_fit_block_allocator
// First-fit block allocator with roving pointer over a word heap memory.
// ----------------------------------------------------------------------------
// Request channel (req_*): op, block_size, block_addr; one response per item.
// Response channel (rsp_*): result_addr and status, held in an output
// register until taken; while a response waits unaccepted, the sequencer
// holds the next item's result in its final state and takes no new item.
// Config channel (csr_*): always ready; index 0 grow_chunk, 1 top_limit.
// After reset a clearing pass writes every heap word, during which
// req_ready is low; config writes are taken meanwhile.
// Allocate and coalesce walk the free ring through the single memory read
// port, merging free neighbors; an allocate that wraps may grow the heap,
// and a fitting allocate carves or unlinks the block. Throughput is one
// item at a time.
// ----------------------------------------------------------------------------
module rover_first_fit_block_allocator
   import rffba_pkg::*;
#(
   parameter int MEM_WORDS = MEM_WORDS_DEF,
   parameter int HEAP_BASE = HEAP_BASE_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_op,
   input  logic [SIZE_W-1:0]     req_block_size,
   input  logic [SIZE_W-1:0]     req_block_addr,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [HALF_W-1:0]     rsp_result_addr,
   output logic                  rsp_status,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   rffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rffba_dpath #(
      .MEM_WORDS (MEM_WORDS),
      .HEAP_BASE (HEAP_BASE)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_valid       (req_valid),
      .req_op          (req_op),
      .req_block_size  (req_block_size),
      .req_block_addr  (req_block_addr),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_addr (rsp_result_addr),
      .rsp_status      (rsp_status)
   );

endmodule
